// ===== rtl/shash64_pkg.sv =====
// shash64_pkg: shared types and mixing functions for the streaming 64-bit string hash.
// Used by shash64_accum, shash64_final and string_hash_64_stream. No dependencies.
`default_nettype none

package shash64_pkg;

	localparam int unsigned HashW = 64;
	localparam int unsigned LenW  = 32;
	localparam int unsigned PendW = 24;

	localparam logic [HashW-1:0] FinalOffset = 64'h0000_0000_1000_0000;

	// Tail byte counts
	localparam logic [1:0] TailNone  = 2'd0;
	localparam logic [1:0] TailOne   = 2'd1;
	localparam logic [1:0] TailTwo   = 2'd2;
	localparam logic [1:0] TailThree = 2'd3;

	// Finished string handed from the accumulator to the finishing pipeline
	typedef struct packed {
		logic [HashW-1:0] acc;
		logic [PendW-1:0] pend;
		logic [1:0]       count;
		logic             empty;
	} tail_t;

	function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
		return {{(HashW-8){b[7]}}, b};
	endfunction

	// Four-byte group: two little-endian 16-bit halves
	function automatic logic [HashW-1:0] mix_group(input logic [HashW-1:0] h_in,
			input logic [15:0] lo16, input logic [15:0] hi16);
		logic [HashW-1:0] h;
		logic [HashW-1:0] t;
		h = h_in + {48'd0, lo16};
		t = ({48'd0, hi16} << 11) ^ h;
		h = (h << 16) ^ t;
		h = h + (h >> 11);
		return h;
	endfunction

	// Leftover 1..3 bytes
	function automatic logic [HashW-1:0] mix_tail(input logic [HashW-1:0] h_in,
			input logic [PendW-1:0] bytes, input logic [1:0] count);
		logic [HashW-1:0] h;
		h = h_in;
		case (count)
			TailThree: begin
				h = h + {48'd0, bytes[15:0]};
				h = h ^ (h << 16);
				h = h ^ (sext8(bytes[23:16]) << 18);
				h = h + (h >> 11);
			end
			TailTwo: begin
				h = h + {48'd0, bytes[15:0]};
				h = h ^ (h << 11);
				h = h + (h >> 17);
			end
			TailOne: begin
				h = h + sext8(bytes[7:0]);
				h = h ^ (h << 10);
				h = h + (h >> 1);
			end
			default: h = h_in;
		endcase
		return h;
	endfunction

	// Avalanche, first four steps
	function automatic logic [HashW-1:0] avalanche_a(input logic [HashW-1:0] h_in);
		logic [HashW-1:0] h;
		h = h_in ^ (h_in << 3);
		h = h + (h >> 5);
		h = h ^ (h << 4);
		h = h + (h >> 17);
		return h;
	endfunction

	// Avalanche, last two steps and the final offset
	function automatic logic [HashW-1:0] avalanche_b(input logic [HashW-1:0] h_in);
		logic [HashW-1:0] h;
		h = h_in ^ (h_in << 25);
		h = h + (h >> 6);
		return h + FinalOffset;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/shash64_accum.sv =====
// shash64_accum: input register and per-byte accumulator update (group mix every fourth byte).
// Depends on shash64_pkg.
`default_nettype none

module shash64_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          byte_valid,
	input  logic [7:0]                    byte_value,
	input  logic [shash64_pkg::LenW-1:0]  string_length,
	input  logic                          last_byte,
	output logic                          valid_s2,
	output shash64_pkg::tail_t            tail_s2
);
	import shash64_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [LenW-1:0]  len_s1;
	logic             last_s1;

	logic [HashW-1:0] acc_q;
	logic [PendW-1:0] pend_q;
	logic [1:0]       pos_q;
	logic             start_q;

	logic             empty;
	logic             emit;
	logic [HashW-1:0] acc_base;
	logic [PendW-1:0] pend_base;
	logic [1:0]       pos_base;
	logic [HashW-1:0] acc_n;
	logic [PendW-1:0] pend_n;
	logic [1:0]       pos_n;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1 <= byte_value;
			len_s1  <= string_length;
			last_s1 <= last_byte;
		end
	end

	// Next accumulator: seed on first byte, buffer bytes, mix on the fourth
	always_comb begin
		empty     = start_q && (len_s1 == '0);
		emit      = empty || last_s1;
		acc_base  = start_q ? {{(HashW-LenW){1'b0}}, len_s1} : acc_q;
		pend_base = start_q ? '0 : pend_q;
		pos_base  = start_q ? TailNone : pos_q;
		acc_n     = acc_base;
		pend_n    = pend_base;
		pos_n     = pos_base + 2'd1;
		case (pos_base)
			TailNone: pend_n[7:0]   = byte_s1;
			TailOne:  pend_n[15:8]  = byte_s1;
			TailTwo:  pend_n[23:16] = byte_s1;
			default: begin
				acc_n  = mix_group(acc_base, pend_base[15:0], {byte_s1, pend_base[23:16]});
				pend_n = '0;
				pos_n  = TailNone;
			end
		endcase
	end

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			pos_q   <= TailNone;
			start_q <= 1'b1;
		end else if (advance && valid_s1 && !empty) begin
			if (last_s1) begin
				acc_q   <= '0;
				pend_q  <= '0;
				pos_q   <= TailNone;
				start_q <= 1'b1;
			end else begin
				acc_q   <= acc_n;
				pend_q  <= pend_n;
				pos_q   <= pos_n;
				start_q <= 1'b0;
			end
		end
	end

	// Hand-off of a finished string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tail_s2.acc   <= acc_n;
			tail_s2.pend  <= pend_n;
			tail_s2.count <= pos_n;
			tail_s2.empty <= empty;
		end
	end

`ifndef SYNTHESIS
	// a final beat always leaves the block at a string start
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && last_s1) |=> start_q)
		else $error("string state not cleared after final beat");

	// an empty string gives a result and keeps the block at a string start
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && start_q && (len_s1 == '0)) |=>
		(valid_s2 && tail_s2.empty && start_q))
		else $error("empty string not passed on as a result");

	// the group buffer is clear whenever it holds no bytes
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == TailNone) |-> (pend_q == '0))
		else $error("stale bytes in group buffer");
`endif

endmodule

`default_nettype wire

// ===== rtl/shash64_final.sv =====
// shash64_final: tail-mix stage, first avalanche stage and the result register, which takes the second avalanche half.
// Depends on shash64_pkg.
`default_nettype none

module shash64_final (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          valid_s2,
	input  shash64_pkg::tail_t            tail_s2,
	output logic                          hash_valid,
	output logic [shash64_pkg::HashW-1:0] hash_value
);
	import shash64_pkg::*;

	logic             valid_s3;
	logic             valid_s4;
	logic             empty_s3;
	logic             empty_s4;
	logic [HashW-1:0] acc_s3;
	logic [HashW-1:0] acc_s4;
	logic             hash_valid_q;
	logic [HashW-1:0] hash_q;

	// Valid flags along the finishing pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			hash_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s3     <= valid_s2;
			valid_s4     <= valid_s3;
			hash_valid_q <= valid_s4;
		end
	end

	// Tail mix, avalanche halves, empty strings forced to zero
	always_ff @(posedge clk) begin
		if (advance) begin
			acc_s3   <= mix_tail(tail_s2.acc, tail_s2.pend, tail_s2.count);
			empty_s3 <= tail_s2.empty;
			acc_s4   <= avalanche_a(acc_s3);
			empty_s4 <= empty_s3;
			hash_q   <= empty_s4 ? '0 : avalanche_b(acc_s4);
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_q;

`ifndef SYNTHESIS
	// a result in the last stage reaches the output register when the pipe moves
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s4) |=> hash_valid_q)
		else $error("result lost between last stage and output");

	// pipeline only frozen while a result is waiting at the output
	a_hold_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> hash_valid_q)
		else $error("pipeline stalled with empty output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/string_hash_64_stream.sv =====
// string_hash_64_stream: streaming 64-bit SuperFastHash-style string hash, one byte per beat.
// A final byte or empty string passes input, hand-off, tail-mix, avalanche and output registers.
// Throughput: one byte per cycle unless held; the group mix sits in the accumulator feedback loop.
// The whole pipeline holds only while a result waits at the output register.
// Reset (arst_n low, asynchronous): pipeline emptied, block waits for the first byte of a string.
// Depends on shash64_pkg, shash64_accum, shash64_final.
`default_nettype none

module string_hash_64_stream (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  logic [7:0]                    byte_value,
	input  logic [shash64_pkg::LenW-1:0]  string_length,
	input  logic                          last_byte,
	output logic                          hash_valid,
	input  logic                          hash_ready,
	output logic [shash64_pkg::HashW-1:0] hash_value
);
	import shash64_pkg::*;

	logic  advance;
	logic  valid_s2;
	tail_t tail_s2;

	// Pipeline moves unless a result sits unclaimed at the output
	assign advance    = !hash_valid || hash_ready;
	assign byte_ready = advance;

	shash64_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.byte_valid    (byte_valid),
		.byte_value    (byte_value),
		.string_length (string_length),
		.last_byte     (last_byte),
		.valid_s2      (valid_s2),
		.tail_s2       (tail_s2)
	);

	shash64_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.valid_s2   (valid_s2),
		.tail_s2    (tail_s2),
		.hash_valid (hash_valid),
		.hash_value (hash_value)
	);

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for string_hash_64_stream, with a byte driver, a hash monitor
// and a cycle-free model of the 64-bit string hash. Depends on shash64_pkg and the block's RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shash64_pkg::*;

	typedef struct packed {
		logic [7:0]      value;
		logic [LenW-1:0] len;
		logic            last;
	} str_beat_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             byte_valid    = 1'b0;
	logic             byte_ready;
	logic [7:0]       byte_value    = '0;
	logic [LenW-1:0]  string_length = '0;
	logic             last_byte     = 1'b0;
	logic             hash_valid;
	logic             hash_ready    = 1'b0;
	logic [HashW-1:0] hash_value;

	// Bytes still to be sent, and hashes owed by the block
	str_beat_t        beat_queue[$];
	logic [HashW-1:0] hash_expected[$];

	// Model state of the hash engine
	logic [HashW-1:0] h_acc   = '0;
	logic [PendW-1:0] h_pend  = '0;
	logic [1:0]       h_fill  = '0;
	logic             h_fresh = 1'b1;

	int unsigned beats_planned  = 0;
	int unsigned beats_accepted = 0;
	int unsigned hashes_seen    = 0;
	int unsigned fail_count     = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	int unsigned idle_pct       = 0;
	int unsigned stall_pct      = 0;

	string_hash_64_stream dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_value   (byte_value),
		.string_length(string_length),
		.last_byte    (last_byte),
		.hash_valid   (hash_valid),
		.hash_ready   (hash_ready),
		.hash_value   (hash_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Fold one byte into the model; returns 1 when a hash comes out
	function automatic logic fold_byte(input logic [7:0] b, input logic [LenW-1:0] len,
			input logic last, output logic [HashW-1:0] hash);
		logic [HashW-1:0] h;
		logic [HashW-1:0] t;
		logic [15:0]      hi;
		hash = '0;
		if (h_fresh) begin
			// empty string: zero straight away, byte dropped
			if (len == '0)
				return 1'b1;
			h_acc   = {{(HashW-LenW){1'b0}}, len};
			h_pend  = '0;
			h_fill  = '0;
			h_fresh = 1'b0;
		end
		if (h_fill == 2'd3) begin
			// fourth byte closes a group of two little-endian halves
			hi = {b, h_pend[23:16]};
			h = h_acc + {48'd0, h_pend[15:0]};
			t = ({48'd0, hi} << 11) ^ h;
			h = (h << 16) ^ t;
			h_acc  = h + (h >> 11);
			h_pend = '0;
			h_fill = '0;
		end else begin
			h_pend[8*h_fill +: 8] = b;
			h_fill = h_fill + 2'd1;
		end
		if (!last)
			return 1'b0;
		// leftover bytes; a lone byte and the third byte are signed
		h = h_acc;
		case (h_fill)
			TailThree: begin
				h = h + {48'd0, h_pend[15:0]};
				h = h ^ (h << 16);
				h = h ^ ({{56{h_pend[23]}}, h_pend[23:16]} << 18);
				h = h + (h >> 11);
			end
			TailTwo: begin
				h = h + {48'd0, h_pend[15:0]};
				h = h ^ (h << 11);
				h = h + (h >> 17);
			end
			TailOne: begin
				h = h + {{56{h_pend[7]}}, h_pend[7:0]};
				h = h ^ (h << 10);
				h = h + (h >> 1);
			end
			default: ;
		endcase
		// avalanche
		h = h ^ (h << 3);
		h = h + (h >> 5);
		h = h ^ (h << 4);
		h = h + (h >> 17);
		h = h ^ (h << 25);
		h = h + (h >> 6);
		hash    = h + FinalOffset;
		h_acc   = '0;
		h_pend  = '0;
		h_fill  = '0;
		h_fresh = 1'b1;
		return 1'b1;
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic [LenW-1:0] len, input logic last);
		str_beat_t beat;
		beat.value = b;
		beat.len   = len;
		beat.last  = last;
		beat_queue = {beat_queue, beat};
		beats_planned++;
	endtask

	// Byte driver: takes beats from the queue, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		str_beat_t        beat;
		logic [HashW-1:0] hash;
		logic             took;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			took = byte_valid && byte_ready;
			if (took) begin
				if (fold_byte(byte_value, string_length, last_byte, hash))
					hash_expected = {hash_expected, hash};
				beats_accepted++;
				if (beats_accepted % 50 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 10;
						default: idle_pct = 40;
					endcase
				end
			end
			if (!byte_valid || took) begin
				if (gap_left != 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (beat_queue.size() != 0) begin
					beat = beat_queue.pop_front();
					byte_value    <= beat.value;
					string_length <= beat.len;
					last_byte     <= beat.last;
					byte_valid    <= 1'b1;
					if (beat_queue.size() >= 60 && $urandom_range(0, 99) < idle_pct)
						gap_left = $urandom_range(1, 15);
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Hash monitor: checks each beat against the oldest expected hash, with random stall bursts on hash_ready
	always @(posedge clk or negedge arst_n) begin
		logic [HashW-1:0] want;
		if (!arst_n) begin
			hash_ready <= 1'b0;
		end else begin
			if (hash_valid && hash_ready) begin
				hashes_seen++;
				if (hash_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected hash beat: got %h", hash_value);
				end else begin
					want = hash_expected.pop_front();
					if (hash_value !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("hash mismatch: expected %h, got %h", want, hash_value);
					end
				end
				if (hashes_seen % 16 == 0)
					stall_pct = $urandom_range(0, 2) * 20;
			end
			if (stall_left != 0) begin
				stall_left--;
				hash_ready <= 1'b0;
			end else begin
				hash_ready <= 1'b1;
				if (beat_queue.size() >= 60 && $urandom_range(0, 99) < stall_pct)
					stall_left = $urandom_range(1, 15);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int unsigned kind;
		int unsigned n;
		logic [LenW-1:0] len;

		// empty strings, with and without the last flag
		add_byte(8'hA5, '0, 1'b0);
		add_byte(8'h3C, '0, 1'b1);
		// one-byte strings across the sign boundary
		add_byte(8'h80, 32'd1, 1'b1);
		add_byte(8'h7F, 32'd1, 1'b1);
		add_byte(8'h00, 32'd1, 1'b1);
		add_byte(8'hFF, 32'd1, 1'b1);
		// two-byte tail
		add_byte(8'hFF, 32'd2, 1'b0);
		add_byte(8'hFF, $urandom, 1'b1);
		// three-byte tail with a negative third byte
		add_byte(8'h01, 32'd3, 1'b0);
		add_byte(8'h02, $urandom, 1'b0);
		add_byte(8'h80, $urandom, 1'b1);
		// three bytes against the largest length
		add_byte(8'h00, 32'hFFFF_FFFF, 1'b0);
		add_byte(8'h00, $urandom, 1'b0);
		add_byte(8'h7F, $urandom, 1'b1);
		// full group, no tail
		for (int i = 0; i < 4; i++)
			add_byte(8'hFF, (i == 0) ? 32'd4 : $urandom, i == 3);
		// group plus one, with a length that disagrees
		for (int i = 0; i < 5; i++)
			add_byte(8'($urandom), (i == 0) ? 32'h8000_0000 : $urandom, i == 4);

		// random strings, mostly well formed
		while (beats_planned < 740) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				add_byte(8'($urandom), '0, 1'($urandom));
			end else begin
				if (kind < 70)
					n = $urandom_range(1, 12);
				else if (kind < 92)
					n = $urandom_range(13, 40);
				else
					n = $urandom_range(41, 80);
				case ($urandom_range(0, 9))
					0: len = $urandom;
					1: len = n + $urandom_range(0, 6) - 3;
					default: len = n;
				endcase
				for (int i = 0; i < n; i++)
					add_byte(8'($urandom), (i == 0) ? len : $urandom, i == n - 1);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (beats_accepted != beats_planned || hash_expected.size() != 0);
		repeat (16) @(posedge clk);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
